// ===== rtl/ss_pkg.sv =====
package ss_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LVL_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned FIELD_W = 7;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_COUNT = 2'd2;
  localparam logic [1:0] REQ_INDEX = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

endpackage

// ===== rtl/ss_req_if.sv =====
interface ss_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink (input valid, req_type, value, output ready);
endinterface

// ===== rtl/ss_rsp_if.sv =====
interface ss_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [6:0]        match_count;
  logic signed [6:0] first_index;
  logic [6:0]        occupancy;

  modport source (output valid, status, match_count, first_index, occupancy, input ready);
  modport sink (input valid, status, match_count, first_index, occupancy, output ready);
endinterface

// ===== rtl/ss_ram.sv =====
module ss_ram (
  input  logic                      clk_i,
  input  ss_pkg::ram_req_t          ram_req_i,
  output logic [ss_pkg::DATA_W-1:0] rdata_o
);
  import ss_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ram_req_i.en) begin
      if (ram_req_i.we) begin
        mem[ram_req_i.addr] <= ram_req_i.wdata;
      end else begin
        rdata_o <= mem[ram_req_i.addr];
      end
    end
  end
endmodule

// ===== rtl/ss_ctrl.sv =====
module ss_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ss_req_if.sink                    req_i,
  ss_rsp_if.source                  rsp_o,
  output ss_pkg::ram_req_t          ram_req_o,
  input  logic [ss_pkg::DATA_W-1:0] rdata_i
);
  import ss_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [1:0]         req_q, req_d;
  logic [DATA_W-1:0]  val_q, val_d;
  logic [LVL_W-1:0]   fill_q, fill_d;
  logic [LVL_W-1:0]   cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic [ADDR_W-1:0]  pidx_q, pidx_d;
  logic [LVL_W-1:0]   mcnt_q, mcnt_d;
  logic [FIELD_W-1:0] first_q, first_d;
  logic               found_q, found_d;
  logic [1:0]         stat_q, stat_d;
  logic               ovld_q, ovld_d;
  logic [1:0]         ostat_q, ostat_d;
  logic [FIELD_W-1:0] omc_q, omc_d;
  logic [FIELD_W-1:0] ofi_q, ofi_d;
  logic [FIELD_W-1:0] oocc_q, oocc_d;
  logic [LVL_W-1:0]   rd_pos;

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = ovld_q;
  assign rsp_o.status      = ostat_q;
  assign rsp_o.match_count = omc_q;
  assign rsp_o.first_index = ofi_q;
  assign rsp_o.occupancy   = oocc_q;

  // The scan walks from the newest entry toward the oldest.
  assign rd_pos = fill_q - LVL_W'(1) - cnt_q;

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    val_d     = val_q;
    fill_d    = fill_q;
    cnt_d     = cnt_q;
    pend_d    = 1'b0;
    pidx_d    = pidx_q;
    mcnt_d    = mcnt_q;
    first_d   = first_q;
    found_d   = found_q;
    stat_d    = stat_q;
    ovld_d    = ovld_q;
    ostat_d   = ostat_q;
    omc_d     = omc_q;
    ofi_d     = ofi_q;
    oocc_d    = oocc_q;
    ram_req_o = '{en: 1'b0, we: 1'b0, addr: fill_q[ADDR_W-1:0], wdata: val_q};

    if (ovld_q && rsp_o.ready) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          req_d   = req_i.req_type;
          val_d   = req_i.value;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        stat_d  = ST_OK;
        mcnt_d  = '0;
        first_d = '0;
        found_d = 1'b0;
        cnt_d   = '0;
        state_d = S_RESP;
        if (req_q == REQ_PUSH) begin
          if (fill_q >= LVL_W'(DEPTH)) begin
            stat_d = ST_FULL;
          end else begin
            ram_req_o.en = 1'b1;
            ram_req_o.we = 1'b1;
            fill_d       = fill_q + LVL_W'(1);
          end
        end else if (fill_q == '0) begin
          stat_d = ST_EMPTY;
        end else if (req_q == REQ_POP) begin
          fill_d = fill_q - LVL_W'(1);
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q < fill_q) begin
          ram_req_o.en   = 1'b1;
          ram_req_o.addr = rd_pos[ADDR_W-1:0];
          pend_d         = 1'b1;
          pidx_d         = cnt_q[ADDR_W-1:0];
          cnt_d          = cnt_q + LVL_W'(1);
        end
        if (pend_q && (rdata_i == val_q)) begin
          if (req_q == REQ_COUNT) begin
            mcnt_d = mcnt_q + LVL_W'(1);
          end else if (!found_q) begin
            first_d = FIELD_W'(pidx_q);
            found_d = 1'b1;
          end
        end
        if ((cnt_q == fill_q) && !pend_q) begin
          if ((req_q == REQ_INDEX) && !found_q) begin
            first_d = '1;
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!ovld_q || rsp_o.ready) begin
          ovld_d  = 1'b1;
          ostat_d = stat_q;
          omc_d   = FIELD_W'(mcnt_q);
          ofi_d   = first_q;
          oocc_d  = FIELD_W'(fill_q);
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      pend_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      pend_q  <= pend_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    val_q   <= val_d;
    cnt_q   <= cnt_d;
    pidx_q  <= pidx_d;
    mcnt_q  <= mcnt_d;
    first_q <= first_d;
    found_q <= found_d;
    stat_q  <= stat_d;
    ostat_q <= ostat_d;
    omc_q   <= omc_d;
    ofi_q   <= ofi_d;
    oocc_q  <= oocc_d;
  end
endmodule

// ===== rtl/search_stack.sv =====
// Channel  Direction  Fields
// req_i    in         req_type, value
// rsp_o    out        status, match_count, first_index, occupancy
//
// One request is worked at a time. Push and pop pass through the execute and
// respond states to the result register; count and index add a scan state,
// a walk over the entry memory through its single port, one read a cycle.
// Reset clears state, fill level, pending and valid flags, not entry memory.
// A result waiting in the output register does not stop the next request
// from being accepted, but its own result waits until that slot is free.
module search_stack (
  input  logic     clk_i,
  input  logic     rst_ni,
  ss_req_if.sink   req_i,
  ss_rsp_if.source rsp_o
);
  import ss_pkg::*;

  ram_req_t          ram_req;
  logic [DATA_W-1:0] rdata;

  ss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .ram_req_o (ram_req),
    .rdata_i   (rdata)
  );

  ss_ram u_ram (
    .clk_i     (clk_i),
    .ram_req_i (ram_req),
    .rdata_o   (rdata)
  );
endmodule

// ===== rtl/ss_checker.sv =====
module ss_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [1:0]        rsp_status,
  input logic [6:0]        rsp_match_count,
  input logic signed [6:0] rsp_first_index,
  input logic [6:0]        rsp_occupancy
);
  import ss_pkg::*;

  // A stalled result must hold.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_occupancy) && $stable(rsp_match_count) && $stable(rsp_first_index))
    else $error("result changed while stalled");

  // Requests are served one at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while another is in work");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_status == ST_EMPTY) |->
      (rsp_occupancy == '0) && (rsp_match_count == '0) && (rsp_first_index == '0))
    else $error("empty error with nonzero fields");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_status == ST_FULL) |-> (rsp_occupancy == FIELD_W'(DEPTH)))
    else $error("full error below capacity");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_match_count != '0) |->
      (rsp_status == ST_OK) && (rsp_match_count <= rsp_occupancy))
    else $error("match count out of range");
endmodule

bind search_stack ss_checker u_ss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid       (req_i.valid),
  .req_ready       (req_i.ready),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .rsp_status      (rsp_o.status),
  .rsp_match_count (rsp_o.match_count),
  .rsp_first_index (rsp_o.first_index),
  .rsp_occupancy   (rsp_o.occupancy)
);

// ===== tb/search_stack_test.sv =====
module search_stack_test;
  import ss_pkg::*;

  typedef struct packed {
    logic [1:0]        status;
    logic [6:0]        match_count;
    logic signed [6:0] first_index;
    logic [6:0]        occupancy;
  } stack_result_t;

  // Shadow copy of the stack plus the queue of results the block still owes.
  class stack_shadow;
    logic signed [31:0] slots [DEPTH];
    int unsigned        level;
    stack_result_t      owed [$];
    int                 errors;
    int                 checked;
    int                 kind_seen [4];
    int                 empty_errs;
    int                 full_errs;
    int                 search_hits;

    function new();
      level = 0;
      errors = 0;
      checked = 0;
      empty_errs = 0;
      full_errs = 0;
      search_hits = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("MISMATCH: %s", what);
    endtask

    function stack_result_t apply_request(logic [1:0] kind, logic signed [31:0] val);
      stack_result_t r;
      int i;
      r = '0;
      r.status = ST_OK;
      if (kind == REQ_PUSH) begin
        if (level >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slots[level] = val;
          level++;
        end
      end else if (level == 0) begin
        r.status = ST_EMPTY;
      end else if (kind == REQ_POP) begin
        level--;
      end else if (kind == REQ_COUNT) begin
        for (i = 0; i < level; i++)
          if (slots[i] == val) r.match_count++;
        if (r.match_count != 0) search_hits++;
      end else begin
        r.first_index = -7'sd1;
        // Position 0 is the newest entry, so the walk runs from the top down.
        for (i = 0; i < level; i++) begin
          if (slots[level - 1 - i] == val) begin
            r.first_index = 7'(i);
            search_hits++;
            break;
          end
        end
      end
      r.occupancy = 7'(level);
      if (r.status == ST_EMPTY) empty_errs++;
      if (r.status == ST_FULL) full_errs++;
      return r;
    endfunction

    function void note_request(logic [1:0] kind, logic signed [31:0] val);
      kind_seen[kind]++;
      owed.push_back(apply_request(kind, val));
    endfunction

    task check_result(stack_result_t got);
      stack_result_t want;
      if (owed.size() == 0) begin
        report($sformatf("result with nothing outstanding (status %0d, occupancy %0d)",
                         got.status, got.occupancy));
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.status !== want.status)
        report($sformatf("result %0d status %0d, expected %0d",
                         checked, got.status, want.status));
      if (got.match_count !== want.match_count)
        report($sformatf("result %0d match_count %0d, expected %0d",
                         checked, got.match_count, want.match_count));
      if (got.first_index !== want.first_index)
        report($sformatf("result %0d first_index %0d, expected %0d",
                         checked, got.first_index, want.first_index));
      if (got.occupancy !== want.occupancy)
        report($sformatf("result %0d occupancy %0d, expected %0d",
                         checked, got.occupancy, want.occupancy));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ss_req_if req_bus ();
  ss_rsp_if rsp_bus ();

  search_stack dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  stack_shadow   sb = new();
  stack_result_t seen;
  int            idle_pct = 0;
  int            stall_pct = 0;
  int            hold_cycles = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Results are checked before the request of the same edge is noted, which
  // keeps the queue order right when both transactions land together.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        seen.status      = rsp_bus.status;
        seen.match_count = rsp_bus.match_count;
        seen.first_index = rsp_bus.first_index;
        seen.occupancy   = rsp_bus.occupancy;
        sb.check_result(seen);
      end
      if (req_bus.valid && req_bus.ready)
        sb.note_request(req_bus.req_type, req_bus.value);
    end
  end

  initial begin : receiver
    int held;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        held = 0;
        hold_cycles = 0;
        rsp_bus.ready <= 1'b0;
        while (held < 400) begin
          @(negedge clk_i);
          held++;
        end
      end
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : watchdog
    #12000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(11))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7FFF_FFFF;
      2: v = 32'sd0;
      3: v = -32'sd1;
      4: v = 32'sh5555_5555;
      5: v = 32'shAAAA_AAAA;
      6: v = 32'sd5;
      7: v = 32'sh1 << $urandom_range(31);
      8: v = ~(32'sh1 << $urandom_range(31));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Called and returning just after a falling edge.
  task automatic send_req(logic [1:0] kind, logic signed [31:0] val);
    while ($urandom_range(99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= kind;
    req_bus.value    <= val;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.owed.size() != 0) @(negedge clk_i);
  endtask

  // Searches look for a value known to be stored half of the time.
  task automatic run_mix(int n, int push_pct, int pop_pct);
    int k;
    int r;
    logic [1:0] kind;
    logic signed [31:0] v;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < push_pct) kind = REQ_PUSH;
      else if (r < push_pct + pop_pct) kind = REQ_POP;
      else kind = $urandom_range(1) ? REQ_COUNT : REQ_INDEX;
      if (kind != REQ_PUSH && sb.level > 0 && $urandom_range(1))
        v = sb.slots[$urandom_range(sb.level - 1)];
      else
        v = pick_value();
      send_req(kind, v);
    end
  endtask

  task automatic fill_and_drain(logic signed [31:0] fill, bit pure_fill);
    while (sb.level < DEPTH)
      send_req(REQ_PUSH, (pure_fill || $urandom_range(3) != 0) ? fill : pick_value());
    send_req(REQ_PUSH, pick_value());
    send_req(REQ_PUSH, pick_value());
    send_req(REQ_COUNT, fill);
    send_req(REQ_INDEX, fill);
    send_req(REQ_INDEX, sb.slots[0]);
    send_req(REQ_COUNT, pick_value());
    while (sb.level > 0) begin
      if ($urandom_range(5) == 0) run_mix(1, 0, 0);
      send_req(REQ_POP, pick_value());
    end
    send_req(REQ_POP, pick_value());
    send_req(REQ_INDEX, fill);
  endtask

  initial begin : stimulus
    int phase;
    int sent;
    int n;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_PUSH;
    req_bus.value    = '0;
    rst_ni           = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Requests on an empty store, the value extremes, hits and misses.
    send_req(REQ_POP, 32'sd0);
    send_req(REQ_COUNT, -32'sd1);
    send_req(REQ_INDEX, 32'sh7FFF_FFFF);
    send_req(REQ_PUSH, 32'sh8000_0000);
    send_req(REQ_PUSH, 32'sh7FFF_FFFF);
    send_req(REQ_PUSH, 32'sd0);
    send_req(REQ_PUSH, -32'sd1);
    send_req(REQ_PUSH, 32'sh7FFF_FFFF);
    send_req(REQ_COUNT, 32'sh7FFF_FFFF);
    send_req(REQ_INDEX, 32'sh7FFF_FFFF);
    send_req(REQ_INDEX, 32'sh8000_0000);
    send_req(REQ_INDEX, 32'sd12345);
    send_req(REQ_COUNT, 32'sh1234);
    send_req(REQ_POP, -32'sd1);
    send_req(REQ_INDEX, 32'sh7FFF_FFFF);
    send_req(REQ_POP, 32'sh5555_5555);
    send_req(REQ_POP, 32'shAAAA_AAAA);
    send_req(REQ_POP, 32'sd0);
    send_req(REQ_POP, 32'sd0);
    send_req(REQ_POP, 32'sd0);
    send_req(REQ_COUNT, -32'sd1);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 52; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 52; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      if (phase == 0 || phase == 3) begin
        // The receiver holds off while requests keep coming, so the block backs up.
        hold_cycles = 400;
        run_mix(30, 80, 5);
      end
      fill_and_drain(pick_value(), phase == 0);
      sent = 0;
      while (sent < 330) begin
        n = $urandom_range(10, 60);
        case ($urandom_range(2))
          0: run_mix(n, 70, 10);
          1: run_mix(n, 10, 60);
          default: run_mix(n, 35, 30);
        endcase
        sent += n;
      end
      wait_drained();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (80) @(negedge clk_i);
    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.owed.size()));

    $display("Checked %0d results: %0d push, %0d pop, %0d count, %0d index requests.",
             sb.checked, sb.kind_seen[REQ_PUSH], sb.kind_seen[REQ_POP],
             sb.kind_seen[REQ_COUNT], sb.kind_seen[REQ_INDEX]);
    $display("Empty-store errors %0d, full-store errors %0d, searches that matched %0d.",
             sb.empty_errs, sb.full_errs, sb.search_hits);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ss_pkg.sv
rtl/ss_req_if.sv
rtl/ss_rsp_if.sv
rtl/ss_ram.sv
rtl/ss_ctrl.sv
rtl/search_stack.sv
rtl/ss_checker.sv
tb/search_stack_test.sv
